@@ rtl/core/laser_line_peak_centroid_macros.svh @@
// assertion macros shared by the laser line peak centroid rtl
`ifndef LASER_LINE_PEAK_CENTROID_MACROS_SVH
`define LASER_LINE_PEAK_CENTROID_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LLPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LLPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/llpc_pkg.sv @@
// shared constants, types and register codes of the laser line peak centroid
package llpc_pkg;

	localparam int ROW_MAX         = 2048;
	localparam int MAX_HALF_WINDOW = 15;
	localparam int FRAC_BITS       = 8;

	localparam int RED_W     = 8;
	localparam int COL_W     = $clog2(ROW_MAX);
	localparam int LEN_W     = 12;
	localparam int HW_W      = 4;
	localparam int SUM_W     = 10;
	localparam int ROWNUM_W  = 12;
	localparam int POS_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	// window walk widths
	localparam int WIN_N_W = $clog2(2 * MAX_HALF_WINDOW + 1);
	localparam int PROD_W  = COL_W + RED_W;
	localparam int NUM_W   = PROD_W + WIN_N_W;
	localparam int DEN_W   = RED_W + WIN_N_W;
	localparam int DIVD_W  = NUM_W + FRAC_BITS;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD   = 2'd0,
		REG_HALF_WINDOW = 2'd1,
		REG_ROW_LENGTH  = 2'd2
	} cfg_reg_t;

	// request handed to the divider
	typedef struct packed {
		logic [DIVD_W-1:0] dividend;
		logic [DEN_W-1:0]  divisor;
	} div_req_t;

endpackage

@@ rtl/core/llpc_pix_if.sv @@
// pixel channel: one red level per transaction
interface llpc_pix_if import llpc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [RED_W-1:0] red;

	modport source (output valid, output red, input ready);
	modport sink (input valid, input red, output ready);
endinterface

@@ rtl/core/llpc_res_if.sv @@
// result channel: one row result per transaction
interface llpc_res_if import llpc_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [ROWNUM_W-1:0] row_number;
	logic                found;
	logic [POS_W-1:0]    position_q8;

	modport source (output valid, output row_number, output found, output position_q8,
		input ready);
	modport sink (input valid, input row_number, input found, input position_q8,
		output ready);
endinterface

@@ rtl/core/llpc_cfg_if.sv @@
// configuration write channel: register index and write data per transaction
interface llpc_cfg_if import llpc_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/laser_line_peak_centroid.sv @@
// Laser line peak centroid: per-row peak detection and sub-pixel centroid.
//
// Channels: pix (sink) takes one red level per transaction, pixel by pixel
// along a row; res (source) gives one result per row: row number, found
// flag and centroid column with 8 fractional bits. cfg (sink) writes the
// threshold, half window and row length registers; it is always ready.
// Throughput: one pixel per cycle within a row. After the last pixel the
// row store is walked over the centroid window, one memory read per cycle
// (2*w+1 reads, w the clipped half window), then the bit-serial divider
// runs; pixels are held off meanwhile. On a zero weight sum the divider is
// skipped; when no peak is found the walk is skipped as well.
// A stalled result sits in the output register while the next row streams
// in; only a second finished row waits for it, holding pix.ready low.
// Reset: registers return to threshold 64, half window 2, row length 2048,
// row counter and column counter to zero. The row store is not cleared:
// every read hits an entry written earlier in the same row.
`include "laser_line_peak_centroid_macros.svh"

module laser_line_peak_centroid import llpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	llpc_pix_if.sink    pix,
	llpc_res_if.source  res,
	llpc_cfg_if.sink    cfg
);

	typedef enum logic [3:0] {
		ST_PIXEL = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [RED_W-1:0] thr_q;
	logic [HW_W-1:0]  hw_q;
	logic [LEN_W-1:0] len_q;

	// row tracking
	logic [COL_W-1:0]    col_q;
	logic [RED_W-1:0]    p1_q;
	logic [RED_W-1:0]    p2_q;
	logic [SUM_W-1:0]    best_sum_q;
	logic [COL_W-1:0]    best_col_q;
	logic                best_found_q;
	logic [ROWNUM_W-1:0] row_cnt_q;

	// row store
	logic [RED_W-1:0] mem [ROW_MAX];

	// window walk
	logic              issue_q;
	logic [COL_W-1:0]  walk_addr_q;
	logic [COL_W-1:0]  walk_last_q;
	logic              v_s1;
	logic [COL_W-1:0]  col_s1;
	logic [RED_W-1:0]  rdata_s1;
	logic              v_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [RED_W-1:0]  red_s2;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;

	// staged and output result
	logic [ROWNUM_W-1:0] stg_row_q;
	logic                stg_found_q;
	logic [POS_W-1:0]    stg_pos_q;
	logic                out_valid_q;
	logic [ROWNUM_W-1:0] out_row_q;
	logic                out_found_q;
	logic [POS_W-1:0]    out_pos_q;

	// divider link
	logic             div_start;
	div_req_t         div_req;
	logic             div_done;
	logic [POS_W-1:0] div_quot;

	// combinational per-pixel logic
	logic             pix_fire;
	logic [LEN_W-1:0] eff_len;
	logic             row_end;
	logic [SUM_W-1:0] thr3;
	logic [SUM_W-1:0] base_sum;
	logic             base_found;
	logic [COL_W-1:0] base_col;
	logic [SUM_W-1:0] sum3;
	logic             hit;
	logic [SUM_W-1:0] nb_sum;
	logic             nb_found;
	logic [COL_W-1:0] nb_col;
	logic [COL_W-1:0] dist_r;
	logic [COL_W-1:0] hw_eff;
	logic [COL_W-1:0] win_a;
	logic [COL_W-1:0] win;
	logic             walk_done;
	logic             out_free;

	assign pix.ready = (state_q == ST_PIXEL);
	assign pix_fire  = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;

	// clamp row length to three..ROW_MAX
	always_comb begin
		eff_len = len_q;
		if (len_q < LEN_W'(3)) eff_len = LEN_W'(3);
		if (len_q > LEN_W'(ROW_MAX)) eff_len = LEN_W'(ROW_MAX);
	end

	assign row_end = (LEN_W'(col_q) + LEN_W'(1)) >= eff_len;
	assign thr3    = SUM_W'(thr_q) + (SUM_W'(thr_q) << 1);

	// peak tracking: best is reloaded at the first pixel of the row
	always_comb begin
		base_sum   = (col_q == '0) ? thr3 : best_sum_q;
		base_found = (col_q == '0) ? 1'b0 : best_found_q;
		base_col   = (col_q == '0) ? '0 : best_col_q;
		sum3       = SUM_W'(p2_q) + SUM_W'(p1_q) + SUM_W'(pix.red);
		hit        = (col_q >= COL_W'(2)) && (sum3 > base_sum);
		nb_sum     = hit ? sum3 : base_sum;
		nb_found   = hit || base_found;
		nb_col     = hit ? col_q - 1'b1 : base_col;
	end

	// half window clipped to the distance from either edge
	always_comb begin
		dist_r = col_q - nb_col;
		hw_eff = (hw_q > HW_W'(MAX_HALF_WINDOW)) ? COL_W'(MAX_HALF_WINDOW) : COL_W'(hw_q);
		win_a  = (nb_col < dist_r) ? nb_col : dist_r;
		win    = (hw_eff < win_a) ? hw_eff : win_a;
	end

	assign walk_done = (state_q == ST_WALK) && !issue_q && !v_s1 && !v_s2;
	assign out_free  = !out_valid_q || res.ready;

	assign div_start        = walk_done && (den_q != '0);
	assign div_req.dividend = {num_q, FRAC_BITS'(0)};
	assign div_req.divisor  = den_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RED_W'(64);
			hw_q  <= HW_W'(2);
			len_q <= LEN_W'(ROW_MAX);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_THRESHOLD:   thr_q <= cfg.data[RED_W-1:0];
				REG_HALF_WINDOW: hw_q  <= cfg.data[HW_W-1:0];
				REG_ROW_LENGTH:  len_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// row store write on pixels, read for the window walk
	always_ff @(posedge clk) begin
		if (pix_fire) mem[col_q] <= pix.red;
		rdata_s1 <= mem[walk_addr_q];
	end

	// main control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_PIXEL;
			col_q        <= '0;
			best_found_q <= 1'b0;
			row_cnt_q    <= '0;
			issue_q      <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_WALK) && issue_q;
			v_s2 <= v_s1;
			// output register: load a finished row, else empty on a transaction
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (res.valid && res.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_PIXEL: begin
					if (pix_fire) begin
						if (row_end) begin
							best_found_q <= 1'b0;
							col_q        <= '0;
							row_cnt_q    <= row_cnt_q + 1'b1;
							issue_q      <= nb_found;
							state_q      <= nb_found ? ST_WALK : ST_OUT;
						end else begin
							best_found_q <= nb_found;
							col_q        <= col_q + 1'b1;
						end
					end
				end
				ST_WALK: begin
					if (issue_q && walk_addr_q == walk_last_q) issue_q <= 1'b0;
					if (walk_done) state_q <= (den_q != '0) ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_PIXEL;
				end
				default: state_q <= ST_PIXEL;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			p2_q       <= p1_q;
			p1_q       <= pix.red;
			best_sum_q <= nb_sum;
			best_col_q <= nb_col;
			if (row_end) begin
				stg_row_q   <= row_cnt_q;
				stg_found_q <= 1'b0;
				stg_pos_q   <= '0;
				walk_addr_q <= nb_col - win;
				walk_last_q <= nb_col + win;
				num_q       <= '0;
				den_q       <= '0;
			end
		end
		if (state_q == ST_WALK && issue_q) begin
			col_s1      <= walk_addr_q;
			walk_addr_q <= walk_addr_q + 1'b1;
		end
		// weight the sample by its column, then accumulate
		prod_s2 <= PROD_W'(col_s1) * PROD_W'(rdata_s1);
		red_s2  <= rdata_s1;
		if (v_s2) begin
			num_q <= num_q + NUM_W'(prod_s2);
			den_q <= den_q + DEN_W'(red_s2);
		end
		if (state_q == ST_DIV && div_done) begin
			stg_found_q <= 1'b1;
			stg_pos_q   <= div_quot;
		end
		if (state_q == ST_OUT && out_free) begin
			out_row_q   <= stg_row_q;
			out_found_q <= stg_found_q;
			out_pos_q   <= stg_pos_q;
		end
	end

	llpc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign res.valid       = out_valid_q;
	assign res.row_number  = out_row_q;
	assign res.found       = out_found_q;
	assign res.position_q8 = out_pos_q;

	// checks
	`LLPC_ASSERT_NOW(a_best_left_of_col, (state_q == ST_PIXEL) && best_found_q,
		best_col_q < col_q, "peak centre not left of the current column")
	`LLPC_ASSERT_NOW(a_div_nonzero, state_q == ST_DIV, den_q != '0,
		"divider running on a zero weight sum")
	`LLPC_ASSERT_NOW(a_miss_zero_pos, out_valid_q && !out_found_q, out_pos_q == '0,
		"position not zero on a row without a peak")
	`LLPC_ASSERT_NEXT(a_load_shows, (state_q == ST_OUT) && out_free, out_valid_q,
		"finished row result not presented")

endmodule

@@ rtl/core/llpc_divider.sv @@
// restoring divider, one quotient bit per cycle
module llpc_divider import llpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  div_req_t         req,
	output logic             done,
	output logic [POS_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] divd_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  dsr_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	// trial subtraction of the divisor from the shifted remainder
	assign trial = {rem_q, divd_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	// datapath: quotient bits shift in at the bottom of the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			divd_q <= req.dividend;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			divd_q <= {divd_q[DIVD_W-2:0], fits};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, dsr_q}) : trial[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = divd_q[POS_W-1:0];

endmodule
